### hw/rtl/sqfs_pkg.sv
// ----------------------------------------------------------------------------
// sqfs_pkg: shared types and constants of the quad SPI flash slave
// Opcodes, register indexes, phase and control encodings, shift-out word.
// ----------------------------------------------------------------------------
package sqfs_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 65536;

  localparam logic [7:0] OP_ID_READ   = 8'h9F;
  localparam logic [7:0] OP_CFG_WRITE = 8'h61;
  localparam logic [7:0] OP_QIO_READ  = 8'hEB;
  localparam logic [7:0] OP_QUAD_READ = 8'hE7;
  localparam logic [7:0] OP_FAST_READ = 8'h0B;
  localparam logic [7:0] OP_READ      = 8'h03;
  localparam logic [7:0] OP_WREN      = 8'h06;
  localparam logic [7:0] OP_SINK      = 8'h81;

  localparam logic [2:0] REG_DUMMY    = 3'd0;
  localparam logic [2:0] REG_ID_MANUF = 3'd1;
  localparam logic [2:0] REG_ID_TYPE  = 3'd2;
  localparam logic [2:0] REG_ID_CAP   = 3'd3;
  localparam logic [2:0] REG_SIZE     = 3'd4;

  localparam logic [7:0]  DUMMY_RST   = 8'd8;
  localparam logic [7:0]  ID_MANUF_RST = 8'h20;
  localparam logic [7:0]  ID_TYPE_RST = 8'hBA;
  localparam logic [7:0]  ID_CAP_RST  = 8'h18;
  localparam logic [7:0]  BYTE_ONES   = 8'hFF;
  localparam logic [3:0]  MASK_SINGLE = 4'h2;
  localparam logic [3:0]  MASK_QUAD   = 4'hF;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CMD, PH_ADDR, PH_MODE, PH_DIN, PH_DUMMY, PH_DOUT, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    C_IDLE, C_DIV, C_RD, C_WB
  } ctl_e;

  typedef struct packed {
    logic [3:0] val;
    logic [3:0] mask;
    logic [7:0] shifter;
    logic [3:0] left;
  } tx_t;

endpackage

### hw/rtl/spi_quad_flash_slave.sv
// ----------------------------------------------------------------------------
// spi_quad_flash_slave: flash side of a SPI bus with quad I/O reads
// Samples the bus pins once per word, decodes command, address, mode and
// dummy phases, and drives single or quad read data from a flash array.
// ----------------------------------------------------------------------------
// A pin word that needs no new flash byte gives its result word in the cycle
//   after acceptance; a word may enter every cycle while results flow and no
//   fetch is busy. A falling edge that fetches a flash byte runs a 24-step
//   remainder (address modulo flash size), one array read, one write-back.
// Reset: asynchronous, active low; clears control state and registers to
//   their defaults. The flash array is not cleared and needs preloading.
module spi_quad_flash_slave
  import sqfs_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic        chip_select_i,
  input  logic        serial_clock_i,
  input  logic [3:0]  data_lines_in_i,
  input  logic [3:0]  controller_enables_i,
  input  logic [15:0] load_address_i,
  input  logic [7:0]  load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  data_lines_out_o,
  output logic [3:0]  drive_enables_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned SW = $clog2(MEM_DEPTH + 1);

  // configuration registers
  logic [7:0]  dummy_cfg_q, id_manuf_q, id_type_q, id_cap_q;
  logic [16:0] flash_size_q;

  // protocol state
  phase_e      phase_q, phase_d;
  logic        last_cs_q, last_cs_d, last_sck_q, last_sck_d;
  logic        rx_quad_q, rx_quad_d, tx_quad_q, tx_quad_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [23:0] rx_shift_q, rx_shift_d;
  logic [4:0]  rx_cnt_q, rx_cnt_d, want_q, want_d;
  logic [23:0] rd_addr_q, rd_addr_d;
  logic [8:0]  dummy_q, dummy_d;
  logic [1:0]  id_pos_q, id_pos_d;
  logic [7:0]  tx_shift_q, tx_shift_d;
  logic [3:0]  tx_left_q, tx_left_d;
  logic [3:0]  drv_val_q, drv_val_d, drv_mask_q, drv_mask_d;
  logic        quad_cmd_q, quad_cmd_d;

  // control of the fetch sequence and the output register
  ctl_e        ctl_q, ctl_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [SW-1:0] rem_q, rem_d;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_data_q, out_data_d, out_en_q, out_en_d;

  logic [SW-1:0] size_eff;
  logic [SW:0]   rem_next;
  logic          out_free, in_acc, rd_en;
  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rdata_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !(ctl_q == C_IDLE && out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o      = out_valid_q;
  assign data_lines_out_o = out_data_q;
  assign drive_enables_o  = out_en_q;

  // clamp the flash size to the array depth
  assign size_eff = ({8'd0, flash_size_q} > 25'(MEM_DEPTH)) ? SW'(MEM_DEPTH)
                                                             : SW'(flash_size_q);

  // one restoring step of address modulo size, address bits MSB first
  always_comb begin
    rem_next = {rem_q, rd_addr_q[div_cnt_q]};
    if (rem_next >= {1'b0, size_eff}) begin
      rem_next = rem_next - {1'b0, size_eff};
    end
  end

  // shift one bit or one nibble out of the transmit byte
  function automatic tx_t shift_out(input logic [7:0] sh, input logic [3:0] left,
                                    input logic quad);
    tx_t r;
    if (quad) begin
      r.val     = sh[7:4];
      r.shifter = {sh[3:0], 4'h0};
      r.left    = (left >= 4'd4) ? left - 4'd4 : 4'd0;
      r.mask    = MASK_QUAD;
    end else begin
      r.val     = {2'b00, sh[7], 1'b0};
      r.shifter = {sh[6:0], 1'b0};
      r.left    = left - 4'd1;
      r.mask    = MASK_SINGLE;
    end
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dummy_cfg_q  <= DUMMY_RST;
      id_manuf_q   <= ID_MANUF_RST;
      id_type_q    <= ID_TYPE_RST;
      id_cap_q     <= ID_CAP_RST;
      flash_size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DUMMY:    dummy_cfg_q  <= cfg_data_i[7:0];
        REG_ID_MANUF: id_manuf_q   <= cfg_data_i[7:0];
        REG_ID_TYPE:  id_type_q    <= cfg_data_i[7:0];
        REG_ID_CAP:   id_cap_q     <= cfg_data_i[7:0];
        REG_SIZE:     flash_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flash array: preload writes, one registered read per fetch
  assign rd_en = (ctl_q == C_RD);
  always_ff @(posedge clk_i) begin
    if (in_acc && command_i && ({9'd0, load_address_i} < 25'(MEM_DEPTH))) begin
      mem[AW'(load_address_i)] <= load_data_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rem_q[AW-1:0]];
    end
  end

  // next state of the bus protocol and the fetch sequence
  always_comb begin
    logic       rq;
    logic [5:0] cnt6;
    logic [23:0] sh;
    tx_t        tx;
    logic       fetched;

    phase_d = phase_q;   last_cs_d = last_cs_q;   last_sck_d = last_sck_q;
    rx_quad_d = rx_quad_q; tx_quad_d = tx_quad_q;  opcode_d = opcode_q;
    rx_shift_d = rx_shift_q; rx_cnt_d = rx_cnt_q; want_d = want_q;
    rd_addr_d = rd_addr_q; dummy_d = dummy_q;     id_pos_d = id_pos_q;
    tx_shift_d = tx_shift_q; tx_left_d = tx_left_q;
    drv_val_d = drv_val_q; drv_mask_d = drv_mask_q; quad_cmd_d = quad_cmd_q;
    ctl_d = ctl_q; div_cnt_d = div_cnt_q; rem_d = rem_q;
    out_data_d = out_data_q; out_en_d = out_en_q;
    out_valid_d = out_valid_q && out_stall_i;
    rq = 1'b0; cnt6 = '0; sh = '0; tx = '0; fetched = 1'b0;

    unique case (ctl_q)
      C_IDLE: begin
        if (in_acc && command_i) begin
          out_valid_d = 1'b1;
          out_data_d  = drv_val_q;
          out_en_d    = drv_mask_q;
        end else if (in_acc) begin
          // chip select edges
          if (last_cs_q && !chip_select_i) begin
            phase_d = PH_CMD; rx_quad_d = quad_cmd_q; want_d = 5'd8;
            rx_shift_d = '0; rx_cnt_d = '0; drv_val_d = '0; drv_mask_d = '0;
          end else if (!last_cs_q && chip_select_i) begin
            phase_d = PH_IDLE; drv_val_d = '0; drv_mask_d = '0;
          end
          last_cs_d  = chip_select_i;
          last_sck_d = serial_clock_i;
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_en_d    = '0;
          if (!chip_select_i) begin
            if (!last_sck_q && serial_clock_i) begin
              if (phase_d == PH_CMD || phase_d == PH_ADDR || phase_d == PH_MODE ||
                  phase_d == PH_DIN) begin
                rq = rx_quad_d;
                if (rx_cnt_d == '0 && (phase_d == PH_ADDR || phase_d == PH_MODE)) begin
                  rq = (controller_enables_i == 4'hF);
                end
                rx_quad_d = rq;
                sh = rq ? {rx_shift_d[19:0], data_lines_in_i}
                        : {rx_shift_d[22:0], data_lines_in_i[0]};
                rx_shift_d = sh;
                cnt6 = {1'b0, rx_cnt_d} + (rq ? 6'd4 : 6'd1);
                rx_cnt_d = (cnt6 > 6'd31) ? 5'd31 : cnt6[4:0];
                if (rx_cnt_d >= want_d) begin
                  unique case (phase_d)
                    PH_CMD: begin
                      opcode_d = sh[7:0];
                      rd_addr_d = '0; rx_shift_d = '0; rx_cnt_d = '0; id_pos_d = '0;
                      tx_left_d = '0; drv_val_d = '0; drv_mask_d = '0;
                      case (sh[7:0]) inside
                        OP_CFG_WRITE, OP_SINK: begin
                          phase_d = PH_DIN; rx_quad_d = 1'b0; want_d = 5'd8;
                        end
                        OP_ID_READ: begin
                          phase_d = PH_DOUT; tx_quad_d = 1'b0;
                        end
                        OP_READ, OP_FAST_READ: begin
                          phase_d = PH_ADDR; rx_quad_d = 1'b0; want_d = 5'd24;
                        end
                        OP_QIO_READ, OP_QUAD_READ: begin
                          phase_d = PH_ADDR; rx_quad_d = 1'b1; want_d = 5'd24;
                        end
                        default: phase_d = PH_DONE;
                      endcase
                    end
                    PH_ADDR: begin
                      rd_addr_d = sh;
                      if (opcode_q == OP_QIO_READ) begin
                        phase_d = PH_MODE; rx_quad_d = 1'b1; want_d = 5'd8;
                        rx_shift_d = '0; rx_cnt_d = '0;
                      end else if (opcode_q == OP_QUAD_READ || opcode_q == OP_FAST_READ) begin
                        phase_d = PH_DUMMY; dummy_d = {1'b0, dummy_cfg_q};
                      end else begin
                        phase_d = PH_DOUT; tx_quad_d = 1'b0; tx_left_d = '0;
                      end
                    end
                    PH_MODE: begin
                      phase_d = PH_DUMMY; dummy_d = {1'b0, dummy_cfg_q};
                    end
                    default: begin
                      if (opcode_q == OP_CFG_WRITE) quad_cmd_d = !sh[7];
                      phase_d = PH_DONE;
                    end
                  endcase
                end
              end else if (phase_d == PH_DUMMY) begin
                if (dummy_d <= 9'd1) begin
                  dummy_d = '0; phase_d = PH_DOUT; tx_left_d = '0;
                  tx_quad_d = (opcode_q == OP_QIO_READ || opcode_q == OP_QUAD_READ);
                end else begin
                  dummy_d = dummy_d - 9'd1;
                end
              end
            end else if (last_sck_q && !serial_clock_i && phase_d == PH_DOUT) begin
              fetched = 1'b1;
              if (tx_left_d == '0) begin
                if (opcode_d == OP_ID_READ) begin
                  unique case (id_pos_d)
                    2'd0:    tx_shift_d = id_manuf_q;
                    2'd1:    tx_shift_d = id_type_q;
                    2'd2:    tx_shift_d = id_cap_q;
                    default: tx_shift_d = BYTE_ONES;
                  endcase
                  if (id_pos_d != 2'd3) id_pos_d = id_pos_d + 2'd1;
                  tx_left_d = 4'd8;
                end else if (size_eff == '0) begin
                  tx_shift_d = BYTE_ONES; tx_left_d = 4'd8;
                  rd_addr_d = rd_addr_d + 24'd1;
                end else begin
                  // hold the result until the flash byte is in
                  fetched = 1'b0;
                  ctl_d = C_DIV; div_cnt_d = 5'd23; rem_d = '0;
                  out_valid_d = 1'b0;
                end
              end
              if (fetched) begin
                tx = shift_out(tx_shift_d, tx_left_d, tx_quad_d);
                tx_shift_d = tx.shifter; tx_left_d = tx.left;
                drv_val_d = tx.val; drv_mask_d = tx.mask;
              end
            end
            if (ctl_d == C_IDLE) begin
              out_data_d = drv_val_d;
              out_en_d   = drv_mask_d;
            end
          end
        end
      end
      C_DIV: begin
        rem_d = rem_next[SW-1:0];
        div_cnt_d = div_cnt_q - 5'd1;
        if (div_cnt_q == '0) ctl_d = C_RD;
      end
      C_RD: ctl_d = C_WB;
      C_WB: begin
        if (out_free) begin
          tx = shift_out(rdata_q, 4'd8, tx_quad_q);
          tx_shift_d = tx.shifter; tx_left_d = tx.left;
          drv_val_d = tx.val; drv_mask_d = tx.mask;
          rd_addr_d = rd_addr_q + 24'd1;
          out_valid_d = 1'b1; out_data_d = tx.val; out_en_d = tx.mask;
          ctl_d = C_IDLE;
        end
      end
      default: ctl_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; last_cs_q <= 1'b1; last_sck_q <= 1'b0;
      rx_quad_q <= 1'b0; tx_quad_q <= 1'b0; opcode_q <= '0;
      rx_shift_q <= '0; rx_cnt_q <= '0; want_q <= '0;
      rd_addr_q <= '0; dummy_q <= '0; id_pos_q <= '0;
      tx_shift_q <= '0; tx_left_q <= '0;
      drv_val_q <= '0; drv_mask_q <= '0; quad_cmd_q <= 1'b0;
      ctl_q <= C_IDLE; div_cnt_q <= '0; rem_q <= '0;
      out_valid_q <= 1'b0; out_data_q <= '0; out_en_q <= '0;
    end else begin
      phase_q <= phase_d; last_cs_q <= last_cs_d; last_sck_q <= last_sck_d;
      rx_quad_q <= rx_quad_d; tx_quad_q <= tx_quad_d; opcode_q <= opcode_d;
      rx_shift_q <= rx_shift_d; rx_cnt_q <= rx_cnt_d; want_q <= want_d;
      rd_addr_q <= rd_addr_d; dummy_q <= dummy_d; id_pos_q <= id_pos_d;
      tx_shift_q <= tx_shift_d; tx_left_q <= tx_left_d;
      drv_val_q <= drv_val_d; drv_mask_q <= drv_mask_d; quad_cmd_q <= quad_cmd_d;
      ctl_q <= ctl_d; div_cnt_q <= div_cnt_d; rem_q <= rem_d;
      out_valid_q <= out_valid_d; out_data_q <= out_data_d; out_en_q <= out_en_d;
    end
  end

  // drive enables only ever take the off, single or quad pattern
  a_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_enables_o == 4'h0 || drive_enables_o == MASK_SINGLE ||
                     drive_enables_o == MASK_QUAD))
    else $error("bad drive enables");

  // the array index stays inside the flash size
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == C_RD) |-> (rem_q < size_eff))
    else $error("flash index out of range");

  // a fetch completes straight after the read, or waits for the output
  a_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == C_WB) |=> (ctl_q == C_IDLE || ctl_q == C_WB))
    else $error("fetch sequence broken");

endmodule
